### rtl/gspe_pkg.sv
// Shared types and constants for the graph shortest-path engine.
// No dependencies; the interfaces, relax unit, top module and bench import this package.
package gspe_pkg;

    localparam int DEF_MAX_VERTICES = 16;
    localparam int DEF_WEIGHT_BITS  = 32;

    localparam int OP_W        = 3;
    localparam int STATUS_W    = 3;
    localparam int VERT_W      = 4;
    localparam int IN_WEIGHT_W = 32;
    localparam int DIST_W      = 36;
    localparam int MAX_RESULTS = 16;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_ADD_VERTEX    = 3'd0,
        OP_ADD_EDGE      = 3'd1,
        OP_REMOVE_EDGE   = 3'd2,
        OP_REMOVE_VERTEX = 3'd3,
        OP_CLEAR         = 3'd4,
        OP_SHORTEST_PATH = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_VTX_EXISTS   = 3'd1,
        ST_VTX_MISSING  = 3'd2,
        ST_SELF_EDGE    = 3'd3,
        ST_EDGE_EXISTS  = 3'd4,
        ST_EDGE_MISSING = 3'd5,
        ST_UNREACHABLE  = 3'd6,
        ST_TOO_FEW      = 3'd7
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_EDGE_CHK,
        S_EDGE_WR2,
        S_VTX_CLR,
        S_RELAX,
        S_SELECT,
        S_WALK_RD,
        S_WALK_CHK,
        S_EMIT_RD,
        S_EMIT_OUT,
        S_STATUS
    } state_t;

    // Per-neighbor flags presented to the relax unit
    typedef struct packed {
        logic edge_present;
        logic vtx_present;
        logic explored;
        logic has_est;
        logic found;
    } relax_ctl_t;

    typedef struct packed {
        logic              update;
        logic              take_min;
        logic [DIST_W-1:0] new_dist;
    } relax_res_t;

endpackage

### rtl/gspe_req_if.sv
// Request channel of the shortest-path engine: valid/ready plus operation fields.
// Depends on gspe_pkg for field widths.
interface gspe_req_if;
    import gspe_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [OP_W-1:0]        op;
    logic [VERT_W-1:0]      vert_a;
    logic [VERT_W-1:0]      vert_b;
    logic [IN_WEIGHT_W-1:0] weight;

    modport source (output valid, output op, output vert_a, output vert_b, output weight,
                    input ready);
    modport sink   (input valid, input op, input vert_a, input vert_b, input weight,
                    output ready);
endinterface

### rtl/gspe_rsp_if.sv
// Result channel of the shortest-path engine: valid/ready plus result fields.
// Depends on gspe_pkg for field widths.
interface gspe_rsp_if;
    import gspe_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [VERT_W-1:0]   path_vertex;
    logic [DIST_W-1:0]   distance;
    logic                last;

    modport source (output valid, output status, output path_vertex, output distance,
                    output last, input ready);
    modport sink   (input valid, input status, input path_vertex, input distance,
                    input last, output ready);
endinterface

### rtl/gspe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gspe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

### rtl/gspe_relax_unit.sv
// Shared relax/compare unit: saturating distance add, estimate update and running minimum.
// Depends on gspe_pkg.
module gspe_relax_unit #(
    parameter int WEIGHT_BITS = gspe_pkg::DEF_WEIGHT_BITS
) (
    input  gspe_pkg::relax_ctl_t          ctl,
    input  logic [gspe_pkg::DIST_W-1:0]   cur_dist,
    input  logic [WEIGHT_BITS-1:0]        weight,
    input  logic [gspe_pkg::DIST_W-1:0]   old_dist,
    input  logic [gspe_pkg::DIST_W-1:0]   best_dist,
    output gspe_pkg::relax_res_t          res
);
    import gspe_pkg::*;

    localparam int SUM_W = ((WEIGHT_BITS > DIST_W) ? WEIGHT_BITS : DIST_W) + 1;

    logic [SUM_W-1:0]  sum;
    logic [DIST_W-1:0] cand;
    logic              relevant;

    assign sum  = SUM_W'(cur_dist) + SUM_W'(weight);
    assign cand = (sum > SUM_W'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];

    assign relevant     = ctl.edge_present && ctl.vtx_present && !ctl.explored;
    assign res.update   = relevant && (!ctl.has_est || (cand < old_dist));
    assign res.new_dist = res.update ? cand : old_dist;
    // strict compare in ascending index order keeps the lowest index on ties
    assign res.take_min = ctl.vtx_present && !ctl.explored && (ctl.has_est || res.update)
                          && (!ctl.found || (res.new_dist < best_dist));
endmodule

### rtl/graph_shortest_path_engine_top.sv
// Shortest-path engine over an undirected weighted graph of up to MAX_VERTICES vertices.
// One request is taken at a time; ready is low while it is worked on. Add vertex clears
// its edge row and column in the edge RAM, one entry per cycle. A path query runs one
// pass per explored vertex through the shared relax unit, which reads one edge and one
// distance per cycle, then walks the predecessors back from the end vertex. Each request
// with a defined op code answers with one status result, or one result per path vertex
// (start first) for a successful query; unused op codes get no result. No clearing pass
// follows reset.
// Depends on gspe_pkg, gspe_req_if, gspe_rsp_if, gspe_ram and gspe_relax_unit.
module graph_shortest_path_engine_top #(
    parameter int MAX_VERTICES = gspe_pkg::DEF_MAX_VERTICES,
    parameter int WEIGHT_BITS  = gspe_pkg::DEF_WEIGHT_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    gspe_req_if.sink    req,
    gspe_rsp_if.source  rsp
);
    import gspe_pkg::*;

    localparam int VIDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int LEN_W  = $clog2(MAX_VERTICES + 1);
    localparam int ADDR_W = $clog2(MAX_VERTICES * MAX_VERTICES);
    localparam int RC_W   = $clog2(MAX_RESULTS + 1);
    localparam int EDGE_W = WEIGHT_BITS + 1;
    localparam int NODE_W = VIDX_W + DIST_W;
    localparam logic [VIDX_W-1:0] LAST_IDX = VIDX_W'(MAX_VERTICES - 1);

    function automatic logic [ADDR_W-1:0] eaddr(input logic [VIDX_W-1:0] x,
                                                 input logic [VIDX_W-1:0] y);
        eaddr = ADDR_W'(x) * ADDR_W'(MAX_VERTICES) + ADDR_W'(y);
    endfunction

    // control state
    state_t                  state_reg, state_next;
    logic [MAX_VERTICES-1:0] vp_reg, vp_next;
    logic [LEN_W-1:0]        vcount_reg, vcount_next;
    logic [MAX_VERTICES-1:0] expl_reg, expl_next;
    logic [MAX_VERTICES-1:0] est_reg, est_next;
    logic                    cons_v_reg, cons_v_next;
    logic                    out_valid_reg, out_valid_next;

    // payload
    op_t                     op_reg, op_next;
    logic [VERT_W-1:0]       a_raw_reg, a_raw_next;
    logic [VERT_W-1:0]       b_raw_reg, b_raw_next;
    logic [WEIGHT_BITS-1:0]  w_reg, w_next;
    logic [LEN_W-1:0]        idx_reg, idx_next;
    logic [VIDX_W-1:0]       cons_idx_reg, cons_idx_next;
    logic [VIDX_W-1:0]       j_reg, j_next;
    logic                    phase_reg, phase_next;
    logic [VIDX_W-1:0]       cur_reg, cur_next;
    logic [DIST_W-1:0]       cur_dist_reg, cur_dist_next;
    logic                    found_reg, found_next;
    logic [DIST_W-1:0]       bd_reg, bd_next;
    logic [VIDX_W-1:0]       best_reg, best_next;
    logic [DIST_W-1:0]       end_dist_reg, end_dist_next;
    logic [LEN_W-1:0]        len_reg, len_next;
    logic [VIDX_W-1:0]       ptr_reg, ptr_next;
    logic [RC_W-1:0]         cnt_reg, cnt_next;
    status_t                 st_reg, st_next;
    status_t                 out_status_reg, out_status_next;
    logic [VERT_W-1:0]       out_vert_reg, out_vert_next;
    logic [DIST_W-1:0]       out_dist_reg, out_dist_next;
    logic                    out_last_reg, out_last_next;

    // memories
    logic                    e_we, e_re;
    logic [ADDR_W-1:0]       e_waddr, e_raddr;
    logic [EDGE_W-1:0]       e_wdata, e_rdata;
    logic                    n_we, n_re;
    logic [VIDX_W-1:0]       n_waddr, n_raddr;
    logic [NODE_W-1:0]       n_wdata, n_rdata;
    logic                    p_we, p_re;
    logic [VIDX_W-1:0]       p_waddr, p_raddr;
    logic [VIDX_W-1:0]       p_wdata, p_rdata;

    // decode helpers
    logic [VIDX_W-1:0]       a_idx, b_idx;
    logic                    a_in, b_in, a_ok, b_ok, same, out_free, edge_p;
    logic                    walk_end, pass_end;
    logic [LEN_W-1:0]        len_inc;
    relax_ctl_t              rctl;
    relax_res_t              rres;

    assign a_idx    = VIDX_W'(a_raw_reg);
    assign b_idx    = VIDX_W'(b_raw_reg);
    assign a_in     = 32'(a_raw_reg) < MAX_VERTICES;
    assign b_in     = 32'(b_raw_reg) < MAX_VERTICES;
    assign a_ok     = a_in && vp_reg[a_idx];
    assign b_ok     = b_in && vp_reg[b_idx];
    assign same     = (a_raw_reg == b_raw_reg);
    assign out_free = !out_valid_reg || rsp.ready;
    assign edge_p   = e_rdata[WEIGHT_BITS];
    assign len_inc  = len_reg + LEN_W'(1);
    assign walk_end = (cur_reg == a_idx) || (32'(len_inc) == MAX_VERTICES);
    assign pass_end = (32'(idx_reg) == MAX_VERTICES) && !cons_v_reg;

    assign rctl.edge_present = edge_p;
    assign rctl.vtx_present  = vp_reg[cons_idx_reg];
    assign rctl.explored     = expl_reg[cons_idx_reg];
    assign rctl.has_est      = est_reg[cons_idx_reg];
    assign rctl.found        = found_reg;

    gspe_relax_unit #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_relax (
        .ctl       (rctl),
        .cur_dist  (cur_dist_reg),
        .weight    (e_rdata[WEIGHT_BITS-1:0]),
        .old_dist  (n_rdata[DIST_W-1:0]),
        .best_dist (bd_reg),
        .res       (rres)
    );

    gspe_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_VERTICES * MAX_VERTICES)) u_edge_ram (
        .clk (clk), .wr_en (e_we), .wr_addr (e_waddr), .wr_data (e_wdata),
        .rd_en (e_re), .rd_addr (e_raddr), .rd_data (e_rdata)
    );

    gspe_ram #(.WIDTH(NODE_W), .DEPTH(MAX_VERTICES)) u_node_ram (
        .clk (clk), .wr_en (n_we), .wr_addr (n_waddr), .wr_data (n_wdata),
        .rd_en (n_re), .rd_addr (n_raddr), .rd_data (n_rdata)
    );

    gspe_ram #(.WIDTH(VIDX_W), .DEPTH(MAX_VERTICES)) u_path_ram (
        .clk (clk), .wr_en (p_we), .wr_addr (p_waddr), .wr_data (p_wdata),
        .rd_en (p_re), .rd_addr (p_raddr), .rd_data (p_rdata)
    );

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.path_vertex = out_vert_reg;
    assign rsp.distance    = out_dist_reg;
    assign rsp.last        = out_last_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (op_reg)
                    OP_ADD_VERTEX:
                        state_next = (!a_in || vp_reg[a_idx]) ? S_STATUS : S_VTX_CLR;
                    OP_ADD_EDGE:
                        state_next = (same || !(a_ok && b_ok)) ? S_STATUS : S_EDGE_CHK;
                    OP_REMOVE_EDGE:
                        state_next = !(a_ok && b_ok) ? S_STATUS : S_EDGE_CHK;
                    OP_REMOVE_VERTEX, OP_CLEAR:
                        state_next = S_STATUS;
                    OP_SHORTEST_PATH:
                    begin
                        if ((vcount_reg < LEN_W'(2)) || !(a_ok && b_ok))
                        begin
                            state_next = S_STATUS;
                        end
                        else
                        begin
                            state_next = same ? S_WALK_RD : S_RELAX;
                        end
                    end
                    default:
                        state_next = S_IDLE;
                endcase
            end
            S_EDGE_CHK:
            begin
                if ((op_reg == OP_ADD_EDGE) ? edge_p : !edge_p)
                begin
                    state_next = S_STATUS;
                end
                else
                begin
                    state_next = S_EDGE_WR2;
                end
            end
            S_EDGE_WR2:
                state_next = S_STATUS;
            S_VTX_CLR:
            begin
                if (phase_reg && (j_reg == LAST_IDX))
                begin
                    state_next = S_STATUS;
                end
            end
            S_RELAX:
            begin
                if (pass_end)
                begin
                    state_next = S_SELECT;
                end
            end
            S_SELECT:
            begin
                if (!found_reg)
                begin
                    state_next = S_STATUS;
                end
                else
                begin
                    state_next = (best_reg == b_idx) ? S_WALK_RD : S_RELAX;
                end
            end
            S_WALK_RD:
                state_next = walk_end ? S_EMIT_RD : S_WALK_CHK;
            S_WALK_CHK:
                state_next = S_WALK_RD;
            S_EMIT_RD:
                state_next = S_EMIT_OUT;
            S_EMIT_OUT:
            begin
                if (out_free)
                begin
                    state_next = (cnt_reg == RC_W'(1)) ? S_IDLE : S_EMIT_RD;
                end
            end
            S_STATUS:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        vp_next         = vp_reg;
        vcount_next     = vcount_reg;
        expl_next       = expl_reg;
        est_next        = est_reg;
        cons_v_next     = 1'b0;
        out_valid_next  = out_valid_reg && !rsp.ready;
        op_next         = op_reg;
        a_raw_next      = a_raw_reg;
        b_raw_next      = b_raw_reg;
        w_next          = w_reg;
        idx_next        = idx_reg;
        cons_idx_next   = cons_idx_reg;
        j_next          = j_reg;
        phase_next      = phase_reg;
        cur_next        = cur_reg;
        cur_dist_next   = cur_dist_reg;
        found_next      = found_reg;
        bd_next         = bd_reg;
        best_next       = best_reg;
        end_dist_next   = end_dist_reg;
        len_next        = len_reg;
        ptr_next        = ptr_reg;
        cnt_next        = cnt_reg;
        st_next         = st_reg;
        out_status_next = out_status_reg;
        out_vert_next   = out_vert_reg;
        out_dist_next   = out_dist_reg;
        out_last_next   = out_last_reg;
        e_we    = 1'b0;
        e_waddr = eaddr(a_idx, b_idx);
        e_wdata = {1'b0, w_reg};
        e_re    = 1'b0;
        e_raddr = eaddr(a_idx, b_idx);
        n_we    = 1'b0;
        n_waddr = cons_idx_reg;
        n_wdata = {cur_reg, rres.new_dist};
        n_re    = 1'b0;
        n_raddr = cur_reg;
        p_we    = 1'b0;
        p_waddr = len_reg[VIDX_W-1:0];
        p_wdata = cur_reg;
        p_re    = 1'b0;
        p_raddr = ptr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = op_t'(req.op);
                    a_raw_next = req.vert_a;
                    b_raw_next = req.vert_b;
                    w_next     = WEIGHT_BITS'(req.weight);
                end
            end
            S_DECODE:
            begin
                unique case (op_reg)
                    OP_ADD_VERTEX:
                    begin
                        j_next     = '0;
                        phase_next = 1'b0;
                        if (!a_in)
                        begin
                            st_next = ST_VTX_MISSING;
                        end
                        else if (vp_reg[a_idx])
                        begin
                            st_next = ST_VTX_EXISTS;
                        end
                    end
                    OP_ADD_EDGE, OP_REMOVE_EDGE:
                    begin
                        if ((op_reg == OP_ADD_EDGE) && same)
                        begin
                            st_next = ST_SELF_EDGE;
                        end
                        else if (!(a_ok && b_ok))
                        begin
                            st_next = ST_VTX_MISSING;
                        end
                        else
                        begin
                            e_re = 1'b1;
                        end
                    end
                    OP_REMOVE_VERTEX:
                    begin
                        if (!a_ok)
                        begin
                            st_next = ST_VTX_MISSING;
                        end
                        else
                        begin
                            vp_next[a_idx] = 1'b0;
                            vcount_next    = vcount_reg - LEN_W'(1);
                            st_next        = ST_OK;
                        end
                    end
                    OP_CLEAR:
                    begin
                        vp_next     = '0;
                        vcount_next = '0;
                        st_next     = ST_OK;
                    end
                    OP_SHORTEST_PATH:
                    begin
                        if (vcount_reg < LEN_W'(2))
                        begin
                            st_next = ST_TOO_FEW;
                        end
                        else if (!(a_ok && b_ok))
                        begin
                            st_next = ST_VTX_MISSING;
                        end
                        else
                        begin
                            // seed the start vertex and explore it first
                            n_we           = 1'b1;
                            n_waddr        = a_idx;
                            n_wdata        = {a_idx, {DIST_W{1'b0}}};
                            est_next       = '0;
                            est_next[a_idx]  = 1'b1;
                            expl_next      = '0;
                            expl_next[a_idx] = 1'b1;
                            cur_next       = a_idx;
                            cur_dist_next  = '0;
                            idx_next       = '0;
                            found_next     = 1'b0;
                            end_dist_next  = '0;
                            len_next       = '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_EDGE_CHK:
            begin
                if (op_reg == OP_ADD_EDGE)
                begin
                    if (edge_p)
                    begin
                        st_next = ST_EDGE_EXISTS;
                    end
                    else
                    begin
                        e_we    = 1'b1;
                        e_wdata = {1'b1, w_reg};
                    end
                end
                else
                begin
                    if (!edge_p)
                    begin
                        st_next = ST_EDGE_MISSING;
                    end
                    else
                    begin
                        e_we = 1'b1;
                    end
                end
            end
            S_EDGE_WR2:
            begin
                e_we    = 1'b1;
                e_waddr = eaddr(b_idx, a_idx);
                e_wdata = {(op_reg == OP_ADD_EDGE), w_reg};
                st_next = ST_OK;
            end
            S_VTX_CLR:
            begin
                // drop stale edges in the new vertex's row, then its column
                e_we    = 1'b1;
                e_waddr = phase_reg ? eaddr(j_reg, a_idx) : eaddr(a_idx, j_reg);
                e_wdata = '0;
                if (j_reg == LAST_IDX)
                begin
                    j_next     = '0;
                    phase_next = 1'b1;
                    if (phase_reg)
                    begin
                        vp_next[a_idx] = 1'b1;
                        vcount_next    = vcount_reg + LEN_W'(1);
                        st_next        = ST_OK;
                    end
                end
                else
                begin
                    j_next = j_reg + VIDX_W'(1);
                end
            end
            S_RELAX:
            begin
                if (32'(idx_reg) < MAX_VERTICES)
                begin
                    e_re          = 1'b1;
                    e_raddr       = eaddr(cur_reg, idx_reg[VIDX_W-1:0]);
                    n_re          = 1'b1;
                    n_raddr       = idx_reg[VIDX_W-1:0];
                    cons_v_next   = 1'b1;
                    cons_idx_next = idx_reg[VIDX_W-1:0];
                    idx_next      = idx_reg + LEN_W'(1);
                end
                if (cons_v_reg)
                begin
                    if (rres.update)
                    begin
                        n_we                   = 1'b1;
                        est_next[cons_idx_reg] = 1'b1;
                    end
                    if (rres.take_min)
                    begin
                        found_next = 1'b1;
                        bd_next    = rres.new_dist;
                        best_next  = cons_idx_reg;
                    end
                end
            end
            S_SELECT:
            begin
                if (!found_reg)
                begin
                    st_next = ST_UNREACHABLE;
                end
                else
                begin
                    expl_next[best_reg] = 1'b1;
                    cur_next            = best_reg;
                    cur_dist_next       = bd_reg;
                    idx_next            = '0;
                    found_next          = 1'b0;
                    end_dist_next       = bd_reg;
                    len_next            = '0;
                end
            end
            S_WALK_RD:
            begin
                p_we     = 1'b1;
                len_next = len_inc;
                if (walk_end)
                begin
                    ptr_next = len_reg[VIDX_W-1:0];
                    cnt_next = (32'(len_inc) < MAX_RESULTS) ? RC_W'(len_inc)
                                                            : RC_W'(MAX_RESULTS);
                end
                else
                begin
                    n_re = 1'b1;
                end
            end
            S_WALK_CHK:
            begin
                cur_next = n_rdata[NODE_W-1:DIST_W];
            end
            S_EMIT_RD:
            begin
                p_re = 1'b1;
            end
            S_EMIT_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_vert_next   = VERT_W'(p_rdata);
                    out_dist_next   = end_dist_reg;
                    out_last_next   = (cnt_reg == RC_W'(1));
                    ptr_next        = ptr_reg - VIDX_W'(1);
                    cnt_next        = cnt_reg - RC_W'(1);
                end
            end
            S_STATUS:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = st_reg;
                    out_vert_next   = '0;
                    out_dist_next   = '0;
                    out_last_next   = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vp_reg        <= '0;
            vcount_reg    <= '0;
            expl_reg      <= '0;
            est_reg       <= '0;
            cons_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            vp_reg        <= vp_next;
            vcount_reg    <= vcount_next;
            expl_reg      <= expl_next;
            est_reg       <= est_next;
            cons_v_reg    <= cons_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        a_raw_reg      <= a_raw_next;
        b_raw_reg      <= b_raw_next;
        w_reg          <= w_next;
        idx_reg        <= idx_next;
        cons_idx_reg   <= cons_idx_next;
        j_reg          <= j_next;
        phase_reg      <= phase_next;
        cur_reg        <= cur_next;
        cur_dist_reg   <= cur_dist_next;
        found_reg      <= found_next;
        bd_reg         <= bd_next;
        best_reg       <= best_next;
        end_dist_reg   <= end_dist_next;
        len_reg        <= len_next;
        ptr_reg        <= ptr_next;
        cnt_reg        <= cnt_next;
        st_reg         <= st_next;
        out_status_reg <= out_status_next;
        out_vert_reg   <= out_vert_next;
        out_dist_reg   <= out_dist_next;
        out_last_reg   <= out_last_next;
    end
endmodule

### verif/graph_shortest_path_engine_top_test.sv
`timescale 1ns / 1ps
// Self-checking bench for graph_shortest_path_engine_top: drives graph edits and path
// queries, predicts each result in a scoreboard class. Depends on gspe_pkg and the
// gspe_req_if / gspe_rsp_if interfaces.
module graph_shortest_path_engine_top_test;
    import gspe_pkg::*;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [VERT_W-1:0]   path_vertex;
        logic [DIST_W-1:0]   distance;
        logic                last;
    } path_result_t;

    class path_scoreboard;
        path_result_t       pending[$];
        int                 mismatches;
        bit                 vtx_on[16];
        bit                 edge_on[16][16];
        logic [31:0]        edge_w[16][16];
        logic [DIST_W-1:0]  best[16];
        logic [3:0]         prev[16];
        bit                 done[16];
        bit                 seen[16];

        function void enqueue(path_result_t r);
            pending.insert(pending.size(), r);
        endfunction

        function void push_status(status_t st);
            path_result_t r;
            r.status = st;
            r.path_vertex = '0;
            r.distance = '0;
            r.last = 1'b1;
            enqueue(r);
        endfunction

        function logic [DIST_W-1:0] sum_sat(logic [DIST_W-1:0] x, logic [31:0] y);
            logic [DIST_W:0] s;
            s = {1'b0, x} + y;
            return s[DIST_W] ? DIST_MAX : s[DIST_W-1:0];
        endfunction

        function void run_path(logic [3:0] src, logic [3:0] dst);
            int cnt;
            int cur;
            bit hit;
            logic [DIST_W-1:0] bd;
            logic [DIST_W-1:0] cand;
            logic [3:0] route[$];
            path_result_t r;
            cnt = 0;
            foreach (vtx_on[i]) if (vtx_on[i]) cnt++;
            if (cnt < 2)
            begin
                push_status(ST_TOO_FEW);
                return;
            end
            if (!vtx_on[src] || !vtx_on[dst])
            begin
                push_status(ST_VTX_MISSING);
                return;
            end
            foreach (done[i])
            begin
                done[i] = 0;
                seen[i] = 0;
            end
            best[src] = '0;
            prev[src] = src;
            seen[src] = 1;
            forever
            begin
                hit = 0;
                bd = '0;
                cur = 0;
                for (int i = 0; i < 16; i++)
                    if (vtx_on[i] && seen[i] && !done[i] && (!hit || best[i] < bd))
                    begin
                        hit = 1;
                        bd = best[i];
                        cur = i;
                    end
                if (!hit)
                begin
                    push_status(ST_UNREACHABLE);
                    return;
                end
                done[cur] = 1;
                if (cur == dst) break;
                for (int i = 0; i < 16; i++)
                    if (edge_on[cur][i] && vtx_on[i] && !done[i])
                    begin
                        cand = sum_sat(best[cur], edge_w[cur][i]);
                        if (!seen[i] || cand < best[i])
                        begin
                            best[i] = cand;
                            prev[i] = cur;
                            seen[i] = 1;
                        end
                    end
            end
            cur = dst;
            while (route.size() < 16)
            begin
                route.push_front(cur);
                if (cur == src) break;
                cur = prev[cur];
            end
            foreach (route[i])
            begin
                r.status = ST_OK;
                r.path_vertex = route[i];
                r.distance = best[dst];
                r.last = (i == route.size() - 1);
                enqueue(r);
            end
        endfunction

        function void note_request(logic [2:0] op, logic [3:0] a, logic [3:0] b,
                                   logic [31:0] w);
            case (op)
                OP_ADD_VERTEX:
                    if (vtx_on[a]) push_status(ST_VTX_EXISTS);
                    else
                    begin
                        vtx_on[a] = 1;
                        push_status(ST_OK);
                    end
                OP_ADD_EDGE:
                    if (a == b) push_status(ST_SELF_EDGE);
                    else if (!vtx_on[a] || !vtx_on[b]) push_status(ST_VTX_MISSING);
                    else if (edge_on[a][b]) push_status(ST_EDGE_EXISTS);
                    else
                    begin
                        edge_on[a][b] = 1;
                        edge_on[b][a] = 1;
                        edge_w[a][b] = w;
                        edge_w[b][a] = w;
                        push_status(ST_OK);
                    end
                OP_REMOVE_EDGE:
                    if (!vtx_on[a] || !vtx_on[b]) push_status(ST_VTX_MISSING);
                    else if (!edge_on[a][b]) push_status(ST_EDGE_MISSING);
                    else
                    begin
                        edge_on[a][b] = 0;
                        edge_on[b][a] = 0;
                        push_status(ST_OK);
                    end
                OP_REMOVE_VERTEX:
                    if (!vtx_on[a]) push_status(ST_VTX_MISSING);
                    else
                    begin
                        vtx_on[a] = 0;
                        for (int i = 0; i < 16; i++)
                        begin
                            edge_on[a][i] = 0;
                            edge_on[i][a] = 0;
                        end
                        push_status(ST_OK);
                    end
                OP_CLEAR:
                begin
                    foreach (vtx_on[i]) vtx_on[i] = 0;
                    foreach (edge_on[i, j]) edge_on[i][j] = 0;
                    push_status(ST_OK);
                end
                OP_SHORTEST_PATH: run_path(a, b);
                default: ;  // unused codes: drop
            endcase
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            mismatches++;
        endtask

        task check_result(path_result_t got);
            path_result_t want;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected result st=%0d v=%0d d=%0d last=%0b",
                       got.status, got.path_vertex, got.distance, got.last));
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.path_vertex !== want.path_vertex)
                report($sformatf("path_vertex %0d, want %0d", got.path_vertex,
                       want.path_vertex));
            if (got.distance !== want.distance)
                report($sformatf("distance %0d, want %0d", got.distance, want.distance));
            if (got.last !== want.last)
                report($sformatf("last %0b, want %0b", got.last, want.last));
        endtask
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;
    path_scoreboard sb;

    gspe_req_if req ();
    gspe_rsp_if rsp ();

    graph_shortest_path_engine_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    // Result side: check at each accepted result, then redraw ready.
    always @(posedge clk or negedge rst_n)
    begin
        path_result_t got;
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got.status = rsp.status;
                got.path_vertex = rsp.path_vertex;
                got.distance = rsp.distance;
                got.last = rsp.last;
                sb.check_result(got);
            end
            rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task send_request(logic [2:0] op, logic [3:0] a, logic [3:0] b, logic [31:0] w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.op <= op;
        req.vert_a <= a;
        req.vert_b <= b;
        req.weight <= w;
        do
            @(posedge clk);
        while (!req.ready);
        sb.note_request(op, a, b, w);
    endtask

    task send_random(int count);
        logic [31:0] w;
        logic [3:0] va;
        logic [3:0] vb;
        int pick;
        for (int n = 0; n < count; n++)
        begin
            w = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(20);
            va = 4'($urandom());
            vb = 4'($urandom());
            pick = $urandom_range(99);
            if (pick < 20)      send_request(OP_ADD_VERTEX, va, vb, w);
            else if (pick < 50) send_request(OP_ADD_EDGE, va, vb, w);
            else if (pick < 55) send_request(OP_REMOVE_EDGE, va, vb, w);
            else if (pick < 60) send_request(OP_REMOVE_VERTEX, va, vb, w);
            else if (pick < 62) send_request(OP_CLEAR, va, vb, w);
            else if (pick < 97) send_request(OP_SHORTEST_PATH, va, vb, w);
            else                send_request(3'($urandom_range(7, 6)), va, vb, w);
        end
    endtask

    initial
    begin
        int waited;
        sb = new();
        send_idle_pct = 20;
        recv_idle_pct = 72;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.op = OP_ADD_VERTEX;
        req.vert_a = '0;
        req.vert_b = '0;
        req.weight = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(OP_SHORTEST_PATH, 4'd0, 4'd15, 32'd0);
        send_request(OP_ADD_VERTEX, 4'd0, 4'd0, 32'd0);
        send_request(OP_ADD_VERTEX, 4'd0, 4'd0, 32'd0);
        send_request(OP_SHORTEST_PATH, 4'd0, 4'd0, 32'd0);
        send_request(OP_ADD_VERTEX, 4'd15, 4'd0, 32'd0);
        send_request(OP_ADD_EDGE, 4'd0, 4'd0, 32'd1);
        send_request(OP_ADD_EDGE, 4'd0, 4'd3, 32'd1);
        send_request(OP_ADD_EDGE, 4'd0, 4'd15, 32'hffff_ffff);
        send_request(OP_ADD_EDGE, 4'd15, 4'd0, 32'd7);
        send_request(OP_ADD_VERTEX, 4'd5, 4'd0, 32'd0);
        send_request(OP_REMOVE_EDGE, 4'd0, 4'd5, 32'd0);
        send_request(OP_SHORTEST_PATH, 4'd0, 4'd5, 32'd0);
        send_request(OP_SHORTEST_PATH, 4'd3, 4'd5, 32'd0);
        send_request(OP_SHORTEST_PATH, 4'd0, 4'd0, 32'd0);
        send_request(OP_SHORTEST_PATH, 4'd0, 4'd15, 32'd0);
        send_request(OP_ADD_EDGE, 4'd15, 4'd5, 32'd0);
        send_request(OP_ADD_EDGE, 4'd0, 4'd5, 32'hffff_ffff);
        send_request(OP_SHORTEST_PATH, 4'd0, 4'd5, 32'd0);
        send_request(OP_REMOVE_VERTEX, 4'd15, 4'd0, 32'd0);
        send_request(OP_REMOVE_VERTEX, 4'd15, 4'd0, 32'd0);
        send_request(OP_REMOVE_EDGE, 4'd0, 4'd5, 32'd0);
        send_request(3'd6, 4'd1, 4'd2, 32'd3);
        send_request(3'd7, 4'd2, 4'd1, 32'd3);
        send_request(OP_CLEAR, 4'd0, 4'd0, 32'd0);
        send_request(OP_SHORTEST_PATH, 4'd0, 4'd5, 32'd0);

        send_random(65);
        send_idle_pct = 72;
        recv_idle_pct = 20;
        send_random(65);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(65);
        req.valid <= 1'b0;

        waited = 0;
        while (sb.pending.size() != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (400) @(posedge clk);
        if (sb.pending.size() == 0 && sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
